// ===== design/wvhp_pkg.sv =====
// Shared types and constants for the wave header parser.
// Holds the transaction structs, the parse phase and chunk kind enums and the chunk tags.
// No dependencies.
`default_nettype none

package wvhp_pkg;

   // Chunk tags as they appear little-endian in a 32-bit shift window
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
   localparam logic [31:0] TAG_FACT = 32'h7463_6166;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [31:0] FMT_MIN_SIZE  = 32'd16;
   localparam logic [31:0] FACT_MIN_SIZE = 32'd4;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_RIFF = 3'd1,
      PH_FMT  = 3'd2,
      PH_HDR  = 3'd3,
      PH_FACT = 3'd4,
      PH_SKIP = 3'd5,
      PH_DONE = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      KIND_OTHER = 2'd0,
      KIND_FACT  = 2'd1,
      KIND_DATA  = 2'd2
   } kind_type;

   typedef enum logic {
      STATUS_OK   = 1'b0,
      STATUS_FAIL = 1'b1
   } status_type;

   typedef struct packed {
      logic [7:0] file_byte;
      logic       start_of_file;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [15:0] audio_format;
      logic [15:0] channel_count;
      logic [31:0] sample_rate;
      logic [15:0] block_align;
      logic [31:0] data_header_offset;
      logic [31:0] data_size;
      logic [31:0] sample_count;
   } rsp_type;

endpackage

`default_nettype wire

// ===== design/wvhp_core.sv =====
// Parse state and single-step byte logic of the wave header parser.
// One byte per step_valid cycle; emits at most one result per step.
// Depends on wvhp_pkg.
`default_nettype none

module wvhp_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step_valid,
   input  wire wvhp_pkg::req_type item,
   output logic                  res_valid,
   output wvhp_pkg::rsp_type     res
);

   localparam logic [4:0] IDX_W0  = 5'd3;
   localparam logic [4:0] IDX_W1  = 5'd7;
   localparam logic [4:0] IDX_FMT_TAG   = 5'd9;
   localparam logic [4:0] IDX_FMT_CHAN  = 5'd11;
   localparam logic [4:0] IDX_FMT_RATE  = 5'd15;
   localparam logic [4:0] IDX_FMT_ALIGN = 5'd21;
   localparam logic [4:0] IDX_FMT_END   = 5'd23;

   wvhp_pkg::phase_type phase_ff, phase_in;
   wvhp_pkg::kind_type  kind_ff, kind_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] cbl_ff, cbl_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] riff_ff, riff_in;
   logic [15:0] fmt_ff, fmt_in;
   logic [15:0] chan_ff, chan_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] align_ff, align_in;
   logic [31:0] samples_ff, samples_in;
   logic [4:0]  bidx_ff, bidx_in;
   logic        bad_ff, bad_in;
   logic [31:0] fact_rest_ff, fact_rest_in;

   always_comb begin
      wvhp_pkg::phase_type phase_e;
      logic [31:0] pos_e;
      logic [31:0] shift_new;
      logic [31:0] skip_cnt;
      logic [31:0] cbl_dec;
      logic [4:0]  idx;
      logic        do_skip;
      logic        do_enter;
      logic        do_fail;

      phase_in     = phase_ff;
      kind_in      = kind_ff;
      pos_in       = pos_ff;
      cbl_in       = cbl_ff;
      shift_in     = shift_ff;
      riff_in      = riff_ff;
      fmt_in       = fmt_ff;
      chan_in      = chan_ff;
      rate_in      = rate_ff;
      align_in     = align_ff;
      samples_in   = samples_ff;
      bidx_in      = bidx_ff;
      bad_in       = bad_ff;
      fact_rest_in = fact_rest_ff;
      res_valid    = 1'b0;
      res          = '0;
      phase_e      = phase_ff;
      pos_e        = pos_ff;
      shift_new    = '0;
      skip_cnt     = '0;
      cbl_dec      = '0;
      idx          = '0;
      do_skip      = 1'b0;
      do_enter     = 1'b0;
      do_fail      = 1'b0;

      if (step_valid) begin
         if (item.start_of_file) begin
            phase_e      = wvhp_pkg::PH_RIFF;
            pos_e        = '0;
            kind_in      = wvhp_pkg::KIND_OTHER;
            cbl_in       = '0;
            shift_in     = '0;
            riff_in      = '0;
            fmt_in       = '0;
            chan_in      = '0;
            rate_in      = '0;
            align_in     = '0;
            samples_in   = 32'd1;
            bidx_in      = '0;
            bad_in       = 1'b0;
            fact_rest_in = '0;
         end
         phase_in = phase_e;
         pos_in   = pos_e;

         if (phase_e != wvhp_pkg::PH_IDLE && phase_e != wvhp_pkg::PH_DONE) begin
            pos_in    = pos_e + 32'd1;
            shift_new = {item.file_byte, shift_in[31:8]};
            shift_in  = shift_new;
            idx       = bidx_in;
            bidx_in   = idx + 5'd1;

            case (phase_e)
               wvhp_pkg::PH_RIFF: begin
                  if (idx == IDX_W0 && shift_new != wvhp_pkg::TAG_RIFF) begin
                     bad_in = 1'b1;
                  end else if (idx == IDX_W1) begin
                     riff_in = shift_new;
                  end else if (idx == IDX_FMT_CHAN) begin
                     if (bad_in || shift_new != wvhp_pkg::TAG_WAVE) begin
                        do_fail = 1'b1;
                     end else begin
                        phase_in = wvhp_pkg::PH_FMT;
                        bidx_in  = '0;
                     end
                  end
               end
               wvhp_pkg::PH_FMT: begin
                  if (idx == IDX_W0) begin
                     if (shift_new != wvhp_pkg::TAG_FMT) begin
                        bad_in = 1'b1;
                     end
                  end else if (idx == IDX_W1) begin
                     cbl_in = shift_new;
                  end else if (idx == IDX_FMT_TAG) begin
                     fmt_in = shift_new[31:16];
                  end else if (idx == IDX_FMT_CHAN) begin
                     chan_in = shift_new[31:16];
                  end else if (idx == IDX_FMT_RATE) begin
                     rate_in = shift_new;
                  end else if (idx == IDX_FMT_ALIGN) begin
                     align_in = shift_new[31:16];
                  end else if (idx == IDX_FMT_END) begin
                     if (bad_in || cbl_in < wvhp_pkg::FMT_MIN_SIZE) begin
                        do_fail = 1'b1;
                     end else begin
                        do_skip  = 1'b1;
                        skip_cnt = cbl_in - wvhp_pkg::FMT_MIN_SIZE;
                     end
                  end
               end
               wvhp_pkg::PH_HDR: begin
                  if (idx == IDX_W0) begin
                     if (shift_new == wvhp_pkg::TAG_FACT) begin
                        kind_in = wvhp_pkg::KIND_FACT;
                     end else if (shift_new == wvhp_pkg::TAG_DATA) begin
                        kind_in = wvhp_pkg::KIND_DATA;
                     end else begin
                        kind_in = wvhp_pkg::KIND_OTHER;
                     end
                  end else if (idx == IDX_W1) begin
                     if (kind_in == wvhp_pkg::KIND_DATA) begin
                        if (shift_new == '0) begin
                           do_fail = 1'b1;
                        end else begin
                           res_valid              = 1'b1;
                           res.status             = wvhp_pkg::STATUS_OK;
                           res.audio_format       = fmt_in;
                           res.channel_count      = chan_in;
                           res.sample_rate        = rate_in;
                           res.block_align        = align_in;
                           res.data_header_offset = pos_e - 32'd7;
                           res.data_size          = shift_new;
                           res.sample_count       = samples_in;
                           phase_in               = wvhp_pkg::PH_DONE;
                        end
                     end else if (kind_in == wvhp_pkg::KIND_FACT &&
                                  shift_new >= wvhp_pkg::FACT_MIN_SIZE) begin
                        fact_rest_in = shift_new - wvhp_pkg::FACT_MIN_SIZE;
                        phase_in     = wvhp_pkg::PH_FACT;
                        bidx_in      = '0;
                     end else begin
                        do_skip  = 1'b1;
                        skip_cnt = shift_new;
                     end
                  end
               end
               wvhp_pkg::PH_FACT: begin
                  if (idx == IDX_W0) begin
                     samples_in = shift_new;
                     do_skip    = 1'b1;
                     skip_cnt   = fact_rest_in;
                  end
               end
               wvhp_pkg::PH_SKIP: begin
                  cbl_dec = cbl_in - 32'd1;
                  cbl_in  = cbl_dec;
                  if (cbl_dec == '0) begin
                     do_enter = 1'b1;
                  end
               end
               default: begin
                  phase_in = wvhp_pkg::PH_DONE;
               end
            endcase

            if (do_skip) begin
               if (skip_cnt == '0) begin
                  do_enter = 1'b1;
               end else begin
                  cbl_in   = skip_cnt;
                  phase_in = wvhp_pkg::PH_SKIP;
               end
            end
            if (do_enter) begin
               if (pos_in >= riff_in) begin
                  do_fail = 1'b1;
               end else begin
                  phase_in = wvhp_pkg::PH_HDR;
                  bidx_in  = '0;
               end
            end
            if (do_fail) begin
               res_valid  = 1'b1;
               res        = '0;
               res.status = wvhp_pkg::STATUS_FAIL;
               phase_in   = wvhp_pkg::PH_DONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= wvhp_pkg::PH_IDLE;
         kind_ff      <= wvhp_pkg::KIND_OTHER;
         pos_ff       <= '0;
         cbl_ff       <= '0;
         shift_ff     <= '0;
         riff_ff      <= '0;
         fmt_ff       <= '0;
         chan_ff      <= '0;
         rate_ff      <= '0;
         align_ff     <= '0;
         samples_ff   <= 32'd1;
         bidx_ff      <= '0;
         bad_ff       <= 1'b0;
         fact_rest_ff <= '0;
      end else begin
         phase_ff     <= phase_in;
         kind_ff      <= kind_in;
         pos_ff       <= pos_in;
         cbl_ff       <= cbl_in;
         shift_ff     <= shift_in;
         riff_ff      <= riff_in;
         fmt_ff       <= fmt_in;
         chan_ff      <= chan_in;
         rate_ff      <= rate_in;
         align_ff     <= align_in;
         samples_ff   <= samples_in;
         bidx_ff      <= bidx_in;
         bad_ff       <= bad_in;
         fact_rest_ff <= fact_rest_in;
      end
   end

   // a result only comes out of a step
   a_res_needs_step: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> step_valid)
      else $error("result without a step");

   // every result closes the file
   a_res_closes: assert property (@(posedge clock) disable iff (reset)
      res_valid |=> phase_ff == wvhp_pkg::PH_DONE)
      else $error("parse still open after result");

   a_ok_nonzero_size: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.status == wvhp_pkg::STATUS_OK) |-> res.data_size != '0)
      else $error("ok result with zero data size");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.status == wvhp_pkg::STATUS_FAIL) |->
         (res.data_size == '0 && res.sample_count == '0 && res.sample_rate == '0))
      else $error("failure result carries data");

   // a byte stepped in before a start has been seen since reset leaves the parse idle
   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == wvhp_pkg::PH_IDLE && step_valid && !item.start_of_file) |=>
         phase_ff == wvhp_pkg::PH_IDLE)
      else $error("left idle without start");

endmodule

`default_nettype wire

// ===== design/wvhp_out.sv =====
// Result register of the wave header parser.
// Holds one result transaction until the receiver takes it; depends on wvhp_pkg.
`default_nettype none

module wvhp_out (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load_valid,
   input  wire wvhp_pkg::rsp_type load_data,
   output logic                   can_take,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output wvhp_pkg::rsp_type      rsp_data
);

   logic              vld_ff, vld_in;
   wvhp_pkg::rsp_type data_ff;

   assign can_take  = !vld_ff || rsp_ready;
   assign vld_in    = can_take ? load_valid : vld_ff;
   assign rsp_valid = vld_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (can_take && load_valid) begin
         data_ff <= load_data;
      end
   end

endmodule

`default_nettype wire

// ===== design/wave_header_parser.sv =====
// Wave header parser: RIFF WAVE header parse over a byte stream.
// Input register on req, parse core, result register on rsp.
// Depends on wvhp_pkg, wvhp_core and wvhp_out.
//
// req carries one file byte per transaction with start_of_file marking byte 0 of a
// file; a start restarts the parse at any point. rsp carries at most one result per
// file: ok with the fmt fields, the data chunk header offset, its size and the fact
// sample count, or a failure with all other fields zero. After a result, bytes are
// dropped until the next start.
// Throughput: one byte per cycle unless a result waits on rsp; each byte is handled by
// one pass of the parse logic between the input register and the result register.
// A result is formed from the byte in the input register and is captured in the result
// register, from which it is offered on rsp.
// Reset: the parse sits idle and ignores bytes until a start; both registers empty.
// Stall: while a result waits on rsp, the input register still takes one byte; the
// next byte is held back only until the waiting result is taken.
`default_nettype none

module wave_header_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire wvhp_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output wvhp_pkg::rsp_type      rsp_data
);

   logic              in_vld_ff, in_vld_in;
   wvhp_pkg::req_type in_data_ff;
   logic              can_take;
   logic              step_fire;
   logic              res_valid;
   wvhp_pkg::rsp_type res;

   assign step_fire = in_vld_ff && can_take;
   assign req_ready = !in_vld_ff || step_fire;
   assign in_vld_in = req_ready ? req_valid : in_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   wvhp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_valid (step_fire),
      .item       (in_data_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   wvhp_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load_valid (res_valid),
      .load_data  (res),
      .can_take   (can_take),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Testbench for wave_header_parser: plays RIFF WAVE byte streams into req and checks rsp.
// Expected results come from a built-in parse predictor; both sides idle and stall at random.
// Depends on wvhp_pkg and wave_header_parser.

module tb_top;
   import wvhp_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 1000;
   localparam int unsigned RANDOM_BYTES   = 1300;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   wave_header_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // parse state mirrored from the block
   phase_type   ph;
   kind_type    kind;
   logic [31:0] fpos, left, window, riff_len, fact_skip, rate_q, samples_q;
   logic [15:0] fmt_q, chans_q, align_q;
   logic [4:0]  hdr_pos;
   bit          tag_bad;
   rsp_type     found;
   rsp_type     expected_rsp[$];
   rsp_type     want;

   int unsigned mismatches = 0;
   int unsigned items_sent = 0;
   int unsigned idle_cycles = 0;
   int unsigned stall_left = 0;
   bit          quiet_mode = 1'b0;
   logic [7:0]  wav_bytes[$];

   function automatic void clear_parse();
      left      = '0;
      window    = '0;
      riff_len  = '0;
      kind      = KIND_OTHER;
      fmt_q     = '0;
      chans_q   = '0;
      rate_q    = '0;
      align_q   = '0;
      samples_q = 32'd1;
      hdr_pos   = '0;
      tag_bad   = 1'b0;
      fact_skip = '0;
   endfunction

   function automatic bit parse_failed();
      found = '0;
      found.status = STATUS_FAIL;
      ph = PH_DONE;
      return 1'b1;
   endfunction

   function automatic bit next_chunk();
      if (fpos >= riff_len) return parse_failed();
      ph = PH_HDR;
      hdr_pos = '0;
      return 1'b0;
   endfunction

   function automatic bit skip_bytes(input logic [31:0] count);
      if (count == 0) return next_chunk();
      left = count;
      ph = PH_SKIP;
      return 1'b0;
   endfunction

   function automatic void predict_byte(input req_type item);
      logic [31:0] pos;
      logic [4:0]  idx;
      bit          hit;
      hit = 1'b0;
      if (item.start_of_file) begin
         clear_parse();
         ph = PH_RIFF;
         fpos = '0;
      end
      if (ph == PH_IDLE || ph == PH_DONE) return;
      pos = fpos;
      fpos = pos + 32'd1;
      window = {item.file_byte, window[31:8]};
      idx = hdr_pos;
      hdr_pos = idx + 5'd1;
      case (ph)
         PH_RIFF: begin
            if (idx == 3 && window != TAG_RIFF) tag_bad = 1'b1;
            else if (idx == 7) riff_len = window;
            else if (idx == 11) begin
               if (tag_bad || window != TAG_WAVE) hit = parse_failed();
               else begin
                  ph = PH_FMT;
                  hdr_pos = '0;
               end
            end
         end
         PH_FMT: begin
            case (idx)
               3: if (window != TAG_FMT) tag_bad = 1'b1;
               7: left = window;
               9: fmt_q = window[31:16];
               11: chans_q = window[31:16];
               15: rate_q = window;
               21: align_q = window[31:16];
               23: begin
                  if (tag_bad || left < FMT_MIN_SIZE) hit = parse_failed();
                  else hit = skip_bytes(left - FMT_MIN_SIZE);
               end
               default: ;
            endcase
         end
         PH_HDR: begin
            if (idx == 3) begin
               if (window == TAG_FACT) kind = KIND_FACT;
               else if (window == TAG_DATA) kind = KIND_DATA;
               else kind = KIND_OTHER;
            end else if (idx == 7) begin
               if (kind == KIND_DATA) begin
                  if (window == 0) hit = parse_failed();
                  else begin
                     found.status             = STATUS_OK;
                     found.audio_format       = fmt_q;
                     found.channel_count      = chans_q;
                     found.sample_rate        = rate_q;
                     found.block_align        = align_q;
                     found.data_header_offset = pos - 32'd7;
                     found.data_size          = window;
                     found.sample_count       = samples_q;
                     ph = PH_DONE;
                     hit = 1'b1;
                  end
               end else if (kind == KIND_FACT && window >= FACT_MIN_SIZE) begin
                  fact_skip = window - FACT_MIN_SIZE;
                  ph = PH_FACT;
                  hdr_pos = '0;
               end else hit = skip_bytes(window);
            end
         end
         PH_FACT: begin
            if (idx == 3) begin
               samples_q = window;
               hit = skip_bytes(fact_skip);
            end
         end
         PH_SKIP: begin
            left = left - 32'd1;
            if (left == 0) hit = next_chunk();
         end
         default: ph = PH_DONE;
      endcase
      if (hit) expected_rsp.push_back(found);
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet_mode || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic logic [15:0] pick16();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'h0000;
      if (r == 1) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   function automatic logic [31:0] pick32();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return 32'h0000_0000;
      if (r == 1) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   // file image builders, little-endian
   function automatic void add_u8(input logic [7:0] b);
      wav_bytes.push_back(b);
   endfunction

   function automatic void add_u16(input logic [15:0] h);
      add_u8(h[7:0]);
      add_u8(h[15:8]);
   endfunction

   function automatic void add_u32(input logic [31:0] w);
      add_u16(w[15:0]);
      add_u16(w[31:16]);
   endfunction

   function automatic void add_wave_head(input logic [31:0] riff, input logic [31:0] fmt_size,
                                         input logic [15:0] code, input logic [15:0] chans,
                                         input logic [31:0] rate, input logic [15:0] align);
      add_u32(TAG_RIFF);
      add_u32(riff);
      add_u32(TAG_WAVE);
      add_u32(TAG_FMT);
      add_u32(fmt_size);
      add_u16(code);
      add_u16(chans);
      add_u32(rate);
      add_u32($urandom);
      add_u16(align);
      add_u16(16'($urandom));
      if (fmt_size > FMT_MIN_SIZE) repeat (fmt_size - FMT_MIN_SIZE) add_u8(8'($urandom));
   endfunction

   function automatic void add_fact(input int unsigned size, input logic [31:0] count);
      add_u32(TAG_FACT);
      add_u32(size);
      if (size >= FACT_MIN_SIZE) begin
         add_u32(count);
         repeat (size - FACT_MIN_SIZE) add_u8(8'($urandom));
      end else repeat (size) add_u8(8'($urandom));
   endfunction

   function automatic void add_other(input int unsigned size);
      logic [31:0] tag;
      tag = $urandom;
      while (tag == TAG_FACT || tag == TAG_DATA) tag = $urandom;
      if ($urandom_range(0, 3) == 0) tag = TAG_FMT;
      add_u32(tag);
      add_u32(size);
      repeat (size) add_u8(8'($urandom));
   endfunction

   function automatic void add_data(input logic [31:0] size);
      add_u32(TAG_DATA);
      add_u32(size);
   endfunction

   function automatic void set_riff_size(input logic [31:0] size);
      wav_bytes[4] = size[7:0];
      wav_bytes[5] = size[15:8];
      wav_bytes[6] = size[23:16];
      wav_bytes[7] = size[31:24];
   endfunction

   task automatic send_byte(input logic [7:0] b, input bit sof);
      req_type     item;
      int unsigned gap;
      item.file_byte = b;
      item.start_of_file = sof;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic play_file();
      foreach (wav_bytes[i]) send_byte(wav_bytes[i], i == 0);
      wav_bytes.delete();
   endtask

   // predictor runs on every accepted transaction
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) predict_byte(req_data);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: status %0d offset %h size %h",
                        rsp_data.status, rsp_data.data_header_offset, rsp_data.data_size);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"result mismatch:\n",
                            "  got  status %0d fmt %h ch %h rate %h align %h off %h size %h n %h\n",
                            "  want status %0d fmt %h ch %h rate %h align %h off %h size %h n %h"},
                           rsp_data.status, rsp_data.audio_format, rsp_data.channel_count,
                           rsp_data.sample_rate, rsp_data.block_align,
                           rsp_data.data_header_offset, rsp_data.data_size,
                           rsp_data.sample_count,
                           want.status, want.audio_format, want.channel_count,
                           want.sample_rate, want.block_align, want.data_header_offset,
                           want.data_size, want.sample_count);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         rsp_ready <= 1'b1;
         stall_left = pick_gap();
      end else begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else idle_cycles <= idle_cycles + 1;
   end

   task automatic test_idle_bytes();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'($urandom), 1'b0);
   endtask

   task automatic test_good_headers();
      add_wave_head(32'hFFFF_FFFF, 16, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
      add_fact(4, 32'hFFFF_FFFF);
      add_data(32'hFFFF_FFFF);
      add_u8(8'hFF);
      add_u8(8'h00);
      play_file();
      add_wave_head(32'hFFFF_FFFF, 16, 16'h0000, 16'h0000, 32'h0000_0000, 16'h0000);
      add_data(32'd1);
      play_file();
   endtask

   task automatic test_bad_magic();
      add_wave_head(32'hFFFF_FFFF, 16, 16'd1, 16'd2, 32'd44100, 16'd4);
      add_data(32'd8);
      wav_bytes[0] = wav_bytes[0] ^ 8'h20;
      play_file();
      add_wave_head(32'hFFFF_FFFF, 16, 16'd1, 16'd2, 32'd44100, 16'd4);
      add_data(32'd8);
      wav_bytes[11] = wav_bytes[11] ^ 8'h01;
      play_file();
   endtask

   task automatic test_fmt_chunk();
      add_wave_head(32'hFFFF_FFFF, 16, 16'd1, 16'd1, 32'd8000, 16'd2);
      add_data(32'd8);
      wav_bytes[12] = wav_bytes[12] ^ 8'h20;
      play_file();
      add_wave_head(32'hFFFF_FFFF, 15, 16'd1, 16'd1, 32'd8000, 16'd2);
      add_data(32'd8);
      play_file();
      add_wave_head(32'hFFFF_FFFF, 21, 16'd3, 16'd6, 32'd96000, 16'd24);
      add_data(32'd100);
      play_file();
   endtask

   task automatic test_fact_and_skip();
      add_wave_head(32'hFFFF_FFFF, 16, pick16(), pick16(), pick32(), pick16());
      add_other(0);
      add_fact(2, 32'd0);
      add_fact(8, $urandom);
      add_other(3);
      add_data($urandom | 32'd1);
      play_file();
   endtask

   task automatic test_zero_data();
      add_wave_head(32'hFFFF_FFFF, 16, 16'd1, 16'd2, 32'd48000, 16'd4);
      add_data(32'd0);
      play_file();
   endtask

   task automatic test_riff_limit();
      add_wave_head(32'hFFFF_FFFF, 16, 16'd1, 16'd2, 32'd48000, 16'd4);
      set_riff_size(wav_bytes.size());
      add_data(32'd5);
      play_file();
      add_wave_head(32'hFFFF_FFFF, 16, 16'd1, 16'd2, 32'd48000, 16'd4);
      add_other(3);
      set_riff_size(wav_bytes.size());
      add_data(32'd5);
      play_file();
   endtask

   task automatic test_restart();
      add_wave_head(32'hFFFF_FFFF, 16, 16'd1, 16'd2, 32'd22050, 16'd4);
      add_data(32'd7);
      while (wav_bytes.size() > 20) void'(wav_bytes.pop_back());
      play_file();
      add_wave_head(32'hFFFF_FFFF, 16, 16'd1, 16'd2, 32'd22050, 16'd4);
      add_data(32'd7);
      play_file();
   endtask

   task automatic test_random_files();
      int unsigned first, r, fmt_size, k;
      first = items_sent;
      while (items_sent - first < RANDOM_BYTES) begin
         if ($urandom_range(0, 9) == 0) quiet_mode = !quiet_mode;
         r = $urandom_range(0, 99);
         if (r < 88) begin
            k = $urandom_range(0, 9);
            if (k == 0) fmt_size = $urandom_range(0, 15);
            else if (k < 3) fmt_size = 16 + $urandom_range(1, 6);
            else fmt_size = 16;
            add_wave_head(32'hFFFF_FFFF, fmt_size, pick16(), pick16(), pick32(), pick16());
            repeat ($urandom_range(0, 2)) begin
               if ($urandom_range(0, 1) == 0) add_fact($urandom_range(0, 9), pick32());
               else add_other($urandom_range(0, 6));
            end
            add_data(pick32());
            repeat ($urandom_range(0, 4)) add_u8(8'($urandom));
            if ($urandom_range(0, 4) == 0) set_riff_size($urandom_range(wav_bytes.size()));
            else set_riff_size($urandom_range(32'hFFFF_FFFF, wav_bytes.size()));
            // broken files: a flipped bit in the headers or a cut-off stream
            if (r >= 75) begin
               if ($urandom_range(0, 1) == 0) begin
                  k = $urandom_range(0, 43);
                  wav_bytes[k] = wav_bytes[k] ^ (8'h01 << $urandom_range(0, 7));
               end else begin
                  k = $urandom_range(1, wav_bytes.size() - 1);
                  while (wav_bytes.size() > k) void'(wav_bytes.pop_back());
               end
            end
            play_file();
         end else if (r < 94) begin
            repeat ($urandom_range(1, 10)) send_byte(8'($urandom), 1'b0);
         end else begin
            repeat ($urandom_range(10, 40)) add_u8(8'($urandom));
            play_file();
         end
      end
      quiet_mode = 1'b0;
   endtask

   initial begin
      clear_parse();
      ph = PH_IDLE;
      fpos = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_idle_bytes();
      test_good_headers();
      test_bad_magic();
      test_fmt_chunk();
      test_fact_and_skip();
      test_zero_data();
      test_riff_limit();
      test_restart();
      test_random_files();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_rsp.size() != 0);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
